FILE: design/minv_pkg.sv
package minv_pkg;

   // Element format
   localparam int DataWidth = 32;
   localparam int FracBits  = 16;

   // Cofactor: sum of six 3-element products, each at most 2^93 in magnitude
   localparam int CofWidth = 3 * DataWidth + 4;
   // Determinant: sum of 24 4-element products, each at most 2^124
   localparam int DetWidth = 4 * DataWidth + 6;
   // Dividend magnitude: cofactor magnitude shifted by 2*FracBits
   localparam int NumWidth = CofWidth + 2 * FracBits;
   localparam int QuoWidth = NumWidth;

   localparam int QuoCntWidth = $clog2(NumWidth + 1);

   typedef logic signed [DataWidth-1:0] elem_type;
   typedef logic signed [CofWidth-1:0]  cof_type;
   typedef logic signed [DetWidth-1:0]  det_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_DET,
      ST_DRAIN,
      ST_COF,
      ST_DIV,
      ST_EMIT
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       store_row;
      logic       det_clear;
      logic       det_step;
      logic       cof_start;
      logic       cof_step;
      logic       div_start;
      logic       div_step;
      logic       div_finish;
      logic [1:0] row_sel;
      logic [1:0] col_sel;
      logic [2:0] term_sel;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic singular;
      logic div_done;
      logic pipe_busy;
   } stat_type;

   // Column triples of the six permutation terms, sign negative for terms 3..5
   function automatic logic [1:0] perm_col(input logic [2:0] p, input logic [1:0] k);
      logic [1:0] r;
      r = 2'd0;
      unique case (p)
         3'd0: r = k;
         3'd1: r = (k == 2'd0) ? 2'd1 : (k == 2'd1) ? 2'd2 : 2'd0;
         3'd2: r = (k == 2'd0) ? 2'd2 : (k == 2'd1) ? 2'd0 : 2'd1;
         3'd3: r = (k == 2'd0) ? 2'd2 : (k == 2'd1) ? 2'd1 : 2'd0;
         3'd4: r = (k == 2'd0) ? 2'd1 : (k == 2'd1) ? 2'd0 : 2'd2;
         3'd5: r = (k == 2'd0) ? 2'd0 : (k == 2'd1) ? 2'd2 : 2'd1;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   // k-th index of {0..3} skipping s
   function automatic logic [1:0] skip_idx(input logic [1:0] s, input logic [1:0] k);
      return (k < s) ? k : k + 2'd1;
   endfunction

endpackage

FILE: design/minv_ctrl.sv
module minv_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic                rsp_tlast,
   output minv_pkg::cmd_type   cmd,
   input  minv_pkg::stat_type  stat
);
   import minv_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] row_ff, row_in;      // input row count / output row
   logic [1:0] col_ff, col_in;      // cofactor column / det column
   logic [2:0] term_ff, term_in;    // permutation term
   logic       accept;
   logic       emit_done;

   assign accept    = req_tvalid && req_tready;
   assign emit_done = rsp_tvalid && rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      term_in  = term_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               row_in = row_ff + 2'd1;
               if (row_ff == 2'd3) begin
                  state_in = ST_DET;
                  col_in   = 2'd0;
                  term_in  = 3'd0;
               end
            end
         end
         ST_DET: begin
            term_in = term_ff + 3'd1;
            if (term_ff == 3'd5) begin
               term_in = 3'd0;
               col_in  = col_ff + 2'd1;
               if (col_ff == 2'd3) begin
                  col_in   = 2'd0;
                  row_in   = 2'd0;
                  state_in = ST_DRAIN;
               end
            end
         end
         // wait for the last determinant term to leave the product pipeline
         ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               if (stat.singular) state_in = ST_EMIT;
               else state_in = ST_COF;
            end
         end
         ST_COF: begin
            term_in = term_ff + 3'd1;
            if (term_ff == 3'd5) begin
               term_in  = 3'd0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               col_in = col_ff + 2'd1;
               if (col_ff == 2'd3) state_in = ST_EMIT;
               else state_in = ST_COF;
            end
         end
         ST_EMIT: begin
            if (emit_done) begin
               row_in = row_ff + 2'd1;
               col_in = 2'd0;
               if (row_ff == 2'd3) state_in = ST_LOAD;
               else if (stat.singular) state_in = ST_EMIT;
               else state_in = ST_COF;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         row_ff   <= 2'd0;
         col_ff   <= 2'd0;
         term_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         term_ff  <= term_in;
      end
   end

   // Outputs
   always_comb begin
      cmd            = '0;
      cmd.row_sel    = row_ff;
      cmd.col_sel    = col_ff;
      cmd.term_sel   = term_ff;
      req_tready     = 1'b0;
      rsp_tvalid     = 1'b0;
      rsp_tlast      = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_tready    = 1'b1;
            cmd.store_row = accept;
            cmd.det_clear = accept && (row_ff == 2'd3);
         end
         ST_DET:  cmd.det_step = 1'b1;
         ST_COF: begin
            cmd.cof_start = (term_ff == 3'd0);
            cmd.cof_step  = 1'b1;
            cmd.div_start = (term_ff == 3'd5);
         end
         ST_DIV: begin
            cmd.div_step   = !stat.div_done;
            cmd.div_finish = stat.div_done;
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            rsp_tlast  = (row_ff == 2'd3);
         end
         default: ;
      endcase
   end

endmodule

FILE: design/minv_datapath.sv
module minv_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  minv_pkg::cmd_type             cmd,
   output minv_pkg::stat_type            stat,
   input  logic [4*minv_pkg::DataWidth-1:0] row_data,
   output logic [4*minv_pkg::DataWidth-1:0] out_data,
   output logic                          out_sat
);
   import minv_pkg::*;

   elem_type   mat_ff [16];
   det_type    det_ff, det_in;
   cof_type    cof_ff;
   logic [DetWidth-1:0] dmag_ff;     // |det|
   logic       dneg_ff;
   logic       sing_ff;

   elem_type   res_ff [4];
   logic       sat_ff;

   function automatic logic [DataWidth-1:0] mag_of(input elem_type v);
      return v[DataWidth-1] ? DataWidth'(-v) : DataWidth'(v);
   endfunction

   // Store rows
   always_ff @(posedge clock) begin
      if (cmd.store_row) begin
         for (int c = 0; c < 4; c++) begin
            mat_ff[{cmd.row_sel, 2'(c)}] <= elem_type'(row_data[c*DataWidth +: DataWidth]);
         end
      end
   end

   // Term selection: minor skips row sr, column sc
   logic [1:0] sr, sc;
   logic [1:0] r0, r1, r2, c0, c1, c2;
   elem_type   e0, e1, e2, ex;

   always_comb begin
      if (cmd.det_step) begin
         sr = 2'd0;
         sc = cmd.col_sel;
      end else begin
         // cofactor(j,i) for output row i = row_sel, column j = col_sel
         sr = cmd.col_sel;
         sc = cmd.row_sel;
      end
      r0 = skip_idx(sr, 2'd0);
      r1 = skip_idx(sr, 2'd1);
      r2 = skip_idx(sr, 2'd2);
      c0 = skip_idx(sc, perm_col(cmd.term_sel, 2'd0));
      c1 = skip_idx(sc, perm_col(cmd.term_sel, 2'd1));
      c2 = skip_idx(sc, perm_col(cmd.term_sel, 2'd2));
      e0 = mat_ff[{r0, c0}];
      e1 = mat_ff[{r1, c1}];
      e2 = mat_ff[{r2, c2}];
      ex = mat_ff[{2'd0, sc}];
   end

   // Term sign and operand magnitudes
   logic [DataWidth-1:0] a0, a1, a2, ax;
   logic                 term_neg;
   assign a0 = mag_of(e0);
   assign a1 = mag_of(e1);
   assign a2 = mag_of(e2);
   assign ax = mag_of(ex);
   assign term_neg = (cmd.term_sel >= 3'd3) ^
                     (cmd.det_step ? sc[0] : (sr[0] ^ sc[0])) ^
                     e0[DataWidth-1] ^ e1[DataWidth-1] ^ e2[DataWidth-1] ^
                     (cmd.det_step && ex[DataWidth-1]);

   // Product pipeline on magnitudes, one DataWidth x DataWidth multiply per stage.
   // Three-element product valid at stage 3, four-element product at stage 6.
   logic [2*DataWidth-1:0] m1_ff, lo2_ff, lo4_ff, hi4_ff;
   logic [DataWidth-1:0]   a2_1_ff, a2_2_ff, hi2_ff, hi5_ff;
   logic [DataWidth-1:0]   ax1_ff, ax2_ff, ax3_ff, ax4_ff, ax5_ff;
   logic [3*DataWidth-1:0] p3_ff, q5_ff;
   logic [4*DataWidth-1:0] p6_ff;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic s1_ff, s2_ff, s3_ff, s4_ff, s5_ff, s6_ff;
   logic det1_ff, det2_ff, det3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.det_step || cmd.cof_step;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff && det3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
      // stage 1
      m1_ff   <= a0 * a1;
      a2_1_ff <= a2;
      ax1_ff  <= ax;
      s1_ff   <= term_neg;
      det1_ff <= cmd.det_step;
      // stage 2
      lo2_ff  <= m1_ff[DataWidth-1:0] * a2_1_ff;
      hi2_ff  <= m1_ff[2*DataWidth-1:DataWidth];
      a2_2_ff <= a2_1_ff;
      ax2_ff  <= ax1_ff;
      s2_ff   <= s1_ff;
      det2_ff <= det1_ff;
      // stage 3
      p3_ff   <= {(2*DataWidth)'(hi2_ff) * a2_2_ff, DataWidth'(0)} +
                 (3*DataWidth)'(lo2_ff);
      ax3_ff  <= ax2_ff;
      s3_ff   <= s2_ff;
      det3_ff <= det2_ff;
      // stage 4
      lo4_ff  <= p3_ff[DataWidth-1:0] * ax3_ff;
      hi4_ff  <= p3_ff[3*DataWidth-1:DataWidth];
      ax4_ff  <= ax3_ff;
      s4_ff   <= s3_ff;
      // stage 5
      q5_ff   <= {(2*DataWidth)'(hi4_ff[DataWidth-1:0]) * ax4_ff, DataWidth'(0)} +
                 (3*DataWidth)'(lo4_ff);
      hi5_ff  <= hi4_ff[2*DataWidth-1:DataWidth];
      ax5_ff  <= ax4_ff;
      s5_ff   <= s4_ff;
      // stage 6
      p6_ff   <= {(2*DataWidth)'(hi5_ff) * ax5_ff, (2*DataWidth)'(0)} +
                 (4*DataWidth)'(q5_ff);
      s6_ff   <= s5_ff;
   end

   // Accumulate determinant and cofactor
   always_comb begin
      det_in = det_ff;
      if (v6_ff) begin
         if (s6_ff) det_in = det_ff - DetWidth'(p6_ff);
         else       det_in = det_ff + DetWidth'(p6_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.det_clear) det_ff <= '0;
      else               det_ff <= det_in;
      if (cmd.cof_start) cof_ff <= '0;
      else if (v3_ff && !det3_ff) begin
         if (s3_ff) cof_ff <= cof_ff - CofWidth'(p3_ff);
         else       cof_ff <= cof_ff + CofWidth'(p3_ff);
      end
      dmag_ff <= det_in[DetWidth-1] ? DetWidth'(-det_in) : DetWidth'(det_in);
      dneg_ff <= det_in[DetWidth-1];
   end

   // Singular flag follows the determinant; read once the pipeline is empty
   logic sing_now;
   assign sing_now = (det_in == '0);
   always_ff @(posedge clock) begin
      if (reset) sing_ff <= 1'b0;
      else       sing_ff <= sing_now;
   end

   // Restoring divider, one quotient bit per cycle. The start waits for the
   // cofactor pipeline to drain via a short delay counter.
   logic [NumWidth-1:0]   num_ff;
   logic [DetWidth:0]     rem_ff;
   logic [QuoWidth-1:0]   quo_ff;
   logic [QuoCntWidth-1:0] cnt_ff;
   logic [2:0]            wait_ff;
   logic                  qneg_ff;
   logic                  busy_ff;
   logic [DetWidth:0]     rem_sh;
   logic                  ge;

   assign rem_sh = {rem_ff[DetWidth-1:0], num_ff[NumWidth-1]};
   assign ge     = (rem_sh >= {1'b0, dmag_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         wait_ff <= 3'd0;
         cnt_ff  <= '0;
      end else if (cmd.div_start) begin
         wait_ff <= 3'd4;
         busy_ff <= 1'b0;
      end else if (wait_ff != 3'd0) begin
         wait_ff <= wait_ff - 3'd1;
         if (wait_ff == 3'd1) begin
            busy_ff <= 1'b1;
            cnt_ff  <= QuoCntWidth'(NumWidth);
         end
      end else if (cmd.div_step && busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == QuoCntWidth'(1)) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wait_ff == 3'd1) begin
         num_ff  <= {(cof_ff[CofWidth-1] ? CofWidth'(-cof_ff) : cof_ff),
                     (2*FracBits)'(0)};
         rem_ff  <= '0;
         quo_ff  <= '0;
         qneg_ff <= cof_ff[CofWidth-1] ^ dneg_ff;
      end else if (cmd.div_step && busy_ff) begin
         num_ff <= {num_ff[NumWidth-2:0], 1'b0};
         rem_ff <= ge ? rem_sh - {1'b0, dmag_ff} : rem_sh;
         quo_ff <= {quo_ff[QuoWidth-2:0], ge};
      end
   end

   assign stat.div_done  = !busy_ff && (wait_ff == 3'd0) && !cmd.div_start &&
                           (cnt_ff == '0);
   assign stat.singular  = sing_ff;
   assign stat.pipe_busy = v1_ff || v2_ff || v3_ff || v4_ff || v5_ff || v6_ff;

   // Saturate and collect into result row
   logic [DataWidth:0] lim;
   logic               clip;
   elem_type           sat_val;
   always_comb begin
      lim  = qneg_ff ? (DataWidth+1)'(1) << (DataWidth-1)
                     : ((DataWidth+1)'(1) << (DataWidth-1)) - 1'b1;
      clip = (quo_ff > QuoWidth'(lim));
      sat_val = clip ? DataWidth'(lim) : quo_ff[DataWidth-1:0];
      if (qneg_ff) sat_val = -sat_val;
   end

   always_ff @(posedge clock) begin
      if (cmd.cof_start && cmd.col_sel == 2'd0) sat_ff <= 1'b0;
      if (cmd.div_finish) begin
         res_ff[cmd.col_sel] <= sat_val;
         if (clip) sat_ff <= 1'b1;
      end
      if (cmd.det_clear) begin
         for (int c = 0; c < 4; c++) res_ff[c] <= '0;
         sat_ff <= 1'b0;
      end
   end

   always_comb begin
      for (int c = 0; c < 4; c++) out_data[c*DataWidth +: DataWidth] = res_ff[c];
   end
   assign out_sat = sat_ff;

endmodule

FILE: design/matrix_inverse_4x4.sv
// Channel  Dir  tdata (low bit up)            tuser (low bit up)         tlast
// req      in   col0, col1, col2, col3        -                          -
// rsp      out  out0, out1, out2, out3        singular, saturated        last_row
//
// A matrix is four req beats. The determinant then takes one product term a
// cycle over all 24 terms, then drains the product pipeline. Each of the 16
// elements then takes six cofactor product terms, a wait for the pipeline to
// drain, one restoring-divider step per quotient bit and a store; a singular
// matrix skips the cofactor and divider steps and returns all-zero rows.
// Reset is synchronous; results hold while rsp_tready is low and no new rows
// are taken until the fourth result row is taken.
module matrix_inverse_4x4 (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // col0, col1, col2, col3
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // out0, out1, out2, out3
   output logic [1:0]   rsp_tuser,   // singular, saturated
   output logic         rsp_tlast
);
   import minv_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     sat;

   minv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .stat       (stat)
   );

   minv_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .row_data (req_tdata),
      .out_data (rsp_tdata),
      .out_sat  (sat)
   );

   assign rsp_tuser = {sat, stat.singular};

`ifndef SYNTH
   // No row accepted while results are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("row taken during output");
   // Singular rows report no clipping
   a_sing_nosat: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> !rsp_tuser[1]) else $error("singular with sat");
   // Singular rows carry zero data
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0)) else $error("singular nonzero");
`endif

endmodule
